// ===== src/mbet_pkg.sv =====
package mbet_pkg;

    localparam int DIM_BITS_DEF   = 12;
    localparam int ITER_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 32;

    localparam int CFG_IDX_W = 3;
    localparam int RST_SIZE  = 512;
    localparam int RST_LIMIT = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_ITER_LIMIT   = 3'd2,
        REG_REAL_MIN     = 3'd3,
        REG_REAL_MAX     = 3'd4,
        REG_IMAG_MIN     = 3'd5,
        REG_IMAG_MAX     = 3'd6
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic cadd;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
    } t_status;

endpackage

// ===== src/mbet_axis.sv =====
module mbet_axis import mbet_pkg::*; #(
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  t_cmd                         i_cmd,
    input  logic [DIM_BITS:0]            i_size,
    input  logic [DIM_BITS-1:0]          i_index,
    input  logic signed [COORD_BITS-1:0] i_lo,
    input  logic signed [COORD_BITS-1:0] i_hi,
    output logic signed [COORD_BITS-1:0] o_c
);

    localparam int DW = COORD_BITS + DIM_BITS;
    localparam int RW = DIM_BITS + 2;

    logic [DIM_BITS:0]     r_den;
    logic [DIM_BITS-1:0]   r_idx;
    logic [COORD_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [DW-1:0]         r_num;
    logic [RW-1:0]         r_rem;
    logic [COORD_BITS-1:0] r_c;

    logic [DIM_BITS:0]     w_den;
    logic [DIM_BITS-1:0]   w_idx;
    logic [COORD_BITS:0]   w_diff;
    logic [COORD_BITS:0]   w_ndiff;
    logic [COORD_BITS-1:0] w_mag;
    logic [DW-1:0]         w_prod;
    logic [RW-1:0]         w_trial;
    logic                  w_ge;
    logic [COORD_BITS:0]   w_sum;
    logic [COORD_BITS:0]   w_lo_ext;
    logic [COORD_BITS:0]   w_q_ext;

    // A size below two acts as two.
    assign w_den = (i_size < (DIM_BITS+1)'(2)) ? (DIM_BITS+1)'(1)
                                               : i_size - (DIM_BITS+1)'(1);
    assign w_idx = ({1'b0, i_index} > w_den) ? w_den[DIM_BITS-1:0] : i_index;

    assign w_diff  = {i_hi[COORD_BITS-1], i_hi} - {i_lo[COORD_BITS-1], i_lo};
    assign w_ndiff = -w_diff;
    assign w_mag   = w_diff[COORD_BITS] ? w_ndiff[COORD_BITS-1:0] : w_diff[COORD_BITS-1:0];

    assign w_prod = r_mag * r_idx;

    // Restoring division, one quotient bit per cycle shifted into r_num.
    assign w_trial = {r_rem[RW-2:0], r_num[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    // The quotient never exceeds the magnitude, so its low bits suffice.
    assign w_lo_ext = {i_lo[COORD_BITS-1], i_lo};
    assign w_q_ext  = {1'b0, r_num[COORD_BITS-1:0]};
    assign w_sum    = r_neg ? w_lo_ext - w_q_ext : w_lo_ext + w_q_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_den <= w_den;
            r_idx <= w_idx;
            r_mag <= w_mag;
            r_neg <= w_diff[COORD_BITS];
        end
        if (i_cmd.mul) begin
            r_num <= w_prod;
            r_rem <= '0;
        end else if (i_cmd.div) begin
            r_num <= {r_num[DW-2:0], w_ge};
            r_rem <= w_ge ? w_trial - {1'b0, r_den} : w_trial;
        end
        if (i_cmd.cadd) begin
            r_c <= w_sum[COORD_BITS-1:0];
        end
    end

    assign o_c = $signed(r_c);

endmodule

// ===== src/mbet_dpath.sv =====
module mbet_dpath import mbet_pkg::*; #(
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int ITER_BITS  = ITER_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    input  logic [DIM_BITS-1:0]          i_col,
    input  logic [DIM_BITS-1:0]          i_row,
    input  logic [DIM_BITS:0]            i_width,
    input  logic [DIM_BITS:0]            i_height,
    input  logic [ITER_BITS-1:0]         i_limit,
    input  logic signed [COORD_BITS-1:0] i_re_min,
    input  logic signed [COORD_BITS-1:0] i_re_max,
    input  logic signed [COORD_BITS-1:0] i_im_min,
    input  logic signed [COORD_BITS-1:0] i_im_max,
    output logic [ITER_BITS-1:0]         o_count
);

    localparam int FRAC = COORD_BITS - 4;
    localparam int ZW   = FRAC + 2;
    localparam int PW   = 2 * ZW;
    localparam int NW   = COORD_BITS + 2;
    localparam int CW   = ITER_BITS + 1;
    localparam logic signed [NW-1:0] BOUND = NW'(1) <<< (FRAC + 1);

    logic signed [COORD_BITS-1:0] w_c_re;
    logic signed [COORD_BITS-1:0] w_c_im;

    logic signed [ZW-1:0]  r_zr;
    logic signed [ZW-1:0]  r_zi;
    logic                  r_oob;
    logic [CW-1:0]         r_n;
    logic [ITER_BITS-1:0]  r_count;

    logic signed [PW-1:0]  w_rr;
    logic signed [PW-1:0]  w_ii;
    logic signed [PW-1:0]  w_ri;
    logic [PW-1:0]         w_mag2;
    logic signed [PW-1:0]  w_diff;
    logic signed [PW-1:0]  w_dsh;
    logic signed [PW-1:0]  w_rsh;
    logic signed [NW-1:0]  w_nr;
    logic signed [NW-1:0]  w_ni;
    logic                  w_oob;
    logic                  w_esc;
    logic                  w_at_lim;
    logic [CW-1:0]         w_nm1;

    mbet_axis #(
        .DIM_BITS   (DIM_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_axis_re (
        .i_clk   (i_clk),
        .i_cmd   (i_cmd),
        .i_size  (i_width),
        .i_index (i_col),
        .i_lo    (i_re_min),
        .i_hi    (i_re_max),
        .o_c     (w_c_re)
    );

    mbet_axis #(
        .DIM_BITS   (DIM_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_axis_im (
        .i_clk   (i_clk),
        .i_cmd   (i_cmd),
        .i_size  (i_height),
        .i_index (i_row),
        .i_lo    (i_im_min),
        .i_hi    (i_im_max),
        .o_c     (w_c_im)
    );

    assign w_rr = r_zr * r_zr;
    assign w_ii = r_zi * r_zi;
    assign w_ri = r_zr * r_zi;

    // While z stays inside the bound, |z|^2 is below 8 and the top two bits
    // of the sum tell whether it has reached 4.
    assign w_mag2 = w_rr + w_ii;
    assign w_esc  = r_oob | (|w_mag2[PW-1:PW-2]);

    // Arithmetic shifts give the round toward minus infinity.
    assign w_diff = w_rr - w_ii;
    assign w_dsh  = w_diff >>> FRAC;
    assign w_rsh  = w_ri >>> (FRAC - 1);
    assign w_nr   = $signed(w_dsh[NW-1:0]) + NW'(w_c_re);
    assign w_ni   = $signed(w_rsh[NW-1:0]) + NW'(w_c_im);
    assign w_oob  = (w_nr >= BOUND) || (w_nr <= -BOUND) ||
                    (w_ni >= BOUND) || (w_ni <= -BOUND);

    assign w_at_lim = r_n == (CW'(i_limit) + CW'(1));
    assign w_nm1    = r_n - CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cadd) begin
            r_zr  <= '0;
            r_zi  <= '0;
            r_oob <= 1'b0;
            r_n   <= '0;
        end else if (i_cmd.step) begin
            r_zr  <= w_nr[ZW-1:0];
            r_zi  <= w_ni[ZW-1:0];
            r_oob <= w_oob;
            r_n   <= r_n + CW'(1);
        end
        if (i_cmd.finish) begin
            r_count <= w_nm1[ITER_BITS-1:0];
        end
    end

    assign o_status.iter_done = w_esc || w_at_lim;
    assign o_count = r_count;

endmodule

// ===== src/mbet_ctrl.sv =====
module mbet_ctrl import mbet_pkg::*; #(
    parameter int DIV_STEPS = COORD_BITS_DEF + DIM_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_done
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIV  = 6'b000100,
        S_ADD  = 6'b001000,
        S_ITER = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.cadd = 1'b1;
                n_state    = S_ITER;
            end
            S_ITER: begin
                if (i_status.iter_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;

endmodule

// ===== src/mandelbrot_escape_time_top.sv =====
// After start is taken the controller loads the axes, multiplies, runs the bit-serial
// divide, adds, then iterates z until escape or the limit and shows the result word.
// Start is taken only in idle, so a pixel is finished before the next is accepted; the pixel
// time is set by the bit-serial coordinate divider and the one-iteration-per-cycle z update.
// The receiver cannot stall: o_done marks the result for one cycle. Reset is synchronous,
// active low; it idles the controller and loads 512 x 512, limit 255, real -2..1, imag -1..1.
module mandelbrot_escape_time_top import mbet_pkg::*; #(
    parameter  int DIM_BITS   = DIM_BITS_DEF,
    parameter  int ITER_BITS  = ITER_BITS_DEF,
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int CFG_W0     = (COORD_BITS > ITER_BITS) ? COORD_BITS : ITER_BITS,
    localparam int CFG_W      = (CFG_W0 > DIM_BITS + 1) ? CFG_W0 : DIM_BITS + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [DIM_BITS-1:0]  i_pixel_col,
    input  logic [DIM_BITS-1:0]  i_pixel_row,
    output logic                 o_done,
    output logic [ITER_BITS-1:0] o_iteration_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int FRAC      = COORD_BITS - 4;
    localparam int DIV_STEPS = COORD_BITS + DIM_BITS;
    localparam logic [COORD_BITS-1:0] ONE_RST    = COORD_BITS'(1) << FRAC;
    localparam logic [COORD_BITS-1:0] TWO_RST    = COORD_BITS'(1) << (FRAC + 1);
    localparam logic [COORD_BITS-1:0] RE_MIN_RST = ~TWO_RST + COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] IM_MIN_RST = ~ONE_RST + COORD_BITS'(1);

    logic [DIM_BITS:0]     r_width;
    logic [DIM_BITS:0]     r_height;
    logic [ITER_BITS-1:0]  r_limit;
    logic [COORD_BITS-1:0] r_re_min;
    logic [COORD_BITS-1:0] r_re_max;
    logic [COORD_BITS-1:0] r_im_min;
    logic [COORD_BITS-1:0] r_im_max;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= (DIM_BITS+1)'(RST_SIZE);
            r_height <= (DIM_BITS+1)'(RST_SIZE);
            r_limit  <= ITER_BITS'(RST_LIMIT);
            r_re_min <= RE_MIN_RST;
            r_re_max <= ONE_RST;
            r_im_min <= IM_MIN_RST;
            r_im_max <= ONE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[DIM_BITS:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[DIM_BITS:0];
                REG_ITER_LIMIT:   r_limit  <= i_cfg_data[ITER_BITS-1:0];
                REG_REAL_MIN:     r_re_min <= i_cfg_data[COORD_BITS-1:0];
                REG_REAL_MAX:     r_re_max <= i_cfg_data[COORD_BITS-1:0];
                REG_IMAG_MIN:     r_im_min <= i_cfg_data[COORD_BITS-1:0];
                REG_IMAG_MAX:     r_im_max <= i_cfg_data[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mbet_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    mbet_dpath #(
        .DIM_BITS   (DIM_BITS),
        .ITER_BITS  (ITER_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_col    (i_pixel_col),
        .i_row    (i_pixel_row),
        .i_width  (r_width),
        .i_height (r_height),
        .i_limit  (r_limit),
        .i_re_min ($signed(r_re_min)),
        .i_re_max ($signed(r_re_max)),
        .i_im_min ($signed(r_im_min)),
        .i_im_max ($signed(r_im_max)),
        .o_count  (o_iteration_count)
    );

    // A pixel ends only through its result word.
    a_end_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> $past(o_done))
        else $error("busy dropped without a result word");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result word outside a pixel");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_iteration_count <= r_limit)
        else $error("iteration count above limit");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule
